### sv/dd_pkg.sv
// Shared types, constants and calendar functions for the date difference block.
package dd_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 22;
   localparam int DNUM_W   = 23;
   localparam int DBM_W    = 9;

   // Reciprocal of 100 scaled by two to the power RECIP_SHIFT; exact for operands below 2^15.
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 19;
   localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_BAD_SMON = 3'd1,
      ST_BAD_SDAY = 3'd2,
      ST_BAD_EMON = 3'd3,
      ST_BAD_EDAY = 3'd4,
      ST_ORDER    = 3'd5
   } status_type;

   typedef struct packed {
      logic load_in;
      logic quo_en;
      logic quo_sel;
      logic num_en;
      logic num_sel;
      logic out_en;
   } dd_cmd_type;

   function automatic logic month_valid(input logic [MONTH_W-1:0] m);
      return (m >= MONTH_JAN) && (m <= MONTH_DEC);
   endfunction

   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
      logic [DAY_W-1:0] len;
      case (m)
         4'd2:                      len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic logic [DBM_W-1:0] days_before(input logic [MONTH_W-1:0] m);
      logic [DBM_W-1:0] n;
      case (m)
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

endpackage

### sv/dd_datapath.sv
// Datapath: input capture, shared year quotient and day number units, result register.
module dd_datapath import dd_pkg::*; (
   input  logic                clock,
   input  dd_cmd_type          cmd,
   input  logic [YEAR_W-1:0]   req_start_year,
   input  logic [MONTH_W-1:0]  req_start_month,
   input  logic [DAY_W-1:0]    req_start_day,
   input  logic [YEAR_W-1:0]   req_end_year,
   input  logic [MONTH_W-1:0]  req_end_month,
   input  logic [DAY_W-1:0]    req_end_day,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_day_count
);

   logic [YEAR_W-1:0]   sy_ff, ey_ff;
   logic [MONTH_W-1:0]  sm_ff, em_ff;
   logic [DAY_W-1:0]    sd_ff, ed_ff;

   logic [YEAR_W-1:0]   qy;
   logic [YEAR_W:0]     qy_p99, qy_p399;
   logic [YEAR_W-2:0]   qy_p399_q4;
   logic [YEAR_W-3:0]   qy_q4;
   logic [27:0]         prod_c100, prod_f100;
   logic [25:0]         prod_c400;
   logic [24:0]         prod_f400;
   logic [7:0]          c100_in, f100_in;
   logic [6:0]          c400_in;
   logic [5:0]          f400_in;
   logic                leap_in;

   logic [YEAR_W-1:0]   qyear_ff;
   logic [7:0]          c100_ff;
   logic [6:0]          c400_ff;
   logic                leap_ff;

   logic [MONTH_W-1:0]  nm;
   logic [DAY_W-1:0]    nd;
   logic [DNUM_W-1:0]   dnum_in;
   logic                mon_bad_in, day_bad_in;
   logic [DNUM_W-1:0]   a_ff, b_ff;
   logic                smon_bad_ff, sday_bad_ff, emon_bad_ff, eday_bad_ff;

   logic [DNUM_W:0]     diff;
   status_type          status_in;
   logic [COUNT_W-1:0]  count_in;
   logic [STATUS_W-1:0] status_ff;
   logic [COUNT_W-1:0]  count_ff;

   // Year quotients: ceilings and floors of y/100 and y/400 decide the leap count and rule.
   always_comb begin
      qy         = cmd.quo_sel ? ey_ff : sy_ff;
      qy_p99     = {1'b0, qy} + 15'd99;
      qy_p399    = {1'b0, qy} + 15'd399;
      qy_p399_q4 = qy_p399[YEAR_W:2];
      qy_q4      = qy[YEAR_W-1:2];
      prod_c100  = 28'(qy_p99) * 28'(RECIP_100);
      prod_f100  = 28'(qy) * 28'(RECIP_100);
      prod_c400  = 26'(qy_p399_q4) * 26'(RECIP_100);
      prod_f400  = 25'(qy_q4) * 25'(RECIP_100);
      c100_in    = prod_c100[RECIP_SHIFT +: 8];
      f100_in    = prod_f100[RECIP_SHIFT +: 8];
      c400_in    = prod_c400[RECIP_SHIFT +: 7];
      f400_in    = prod_f400[RECIP_SHIFT +: 6];
      leap_in    = ((qy[1:0] == 2'd0) && (c100_in != f100_in)) ||
                   (c400_in == {1'b0, f400_in});
   end

   // Day number counted from the first day of year zero.
   always_comb begin
      nm         = cmd.num_sel ? em_ff : sm_ff;
      nd         = cmd.num_sel ? ed_ff : sd_ff;
      dnum_in    = DNUM_W'(qyear_ff) * DNUM_W'(365)
                   + DNUM_W'((15'(qyear_ff) + 15'd3) >> 2)
                   - DNUM_W'(c100_ff) + DNUM_W'(c400_ff)
                   + DNUM_W'(days_before(nm))
                   + DNUM_W'((nm > MONTH_FEB) && leap_ff)
                   + DNUM_W'(nd);
      mon_bad_in = !month_valid(nm);
      day_bad_in = (nd == '0) || (nd > month_length(nm, leap_ff));
   end

   always_comb begin
      diff     = {1'b0, b_ff} - {1'b0, a_ff};
      count_in = '0;
      if (smon_bad_ff) begin
         status_in = ST_BAD_SMON;
      end else if (sday_bad_ff) begin
         status_in = ST_BAD_SDAY;
      end else if (emon_bad_ff) begin
         status_in = ST_BAD_EMON;
      end else if (eday_bad_ff) begin
         status_in = ST_BAD_EDAY;
      end else if (diff[DNUM_W]) begin
         status_in = ST_ORDER;
      end else begin
         status_in = ST_OK;
         count_in  = diff[DNUM_W-1] ? COUNT_MAX : diff[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         sy_ff <= req_start_year;
         sm_ff <= req_start_month;
         sd_ff <= req_start_day;
         ey_ff <= req_end_year;
         em_ff <= req_end_month;
         ed_ff <= req_end_day;
      end
      if (cmd.quo_en) begin
         qyear_ff <= qy;
         c100_ff  <= c100_in;
         c400_ff  <= c400_in;
         leap_ff  <= leap_in;
      end
      if (cmd.num_en) begin
         if (cmd.num_sel) begin
            b_ff        <= dnum_in;
            emon_bad_ff <= mon_bad_in;
            eday_bad_ff <= day_bad_in;
         end else begin
            a_ff        <= dnum_in;
            smon_bad_ff <= mon_bad_in;
            sday_bad_ff <= day_bad_in;
         end
      end
      if (cmd.out_en) begin
         status_ff <= status_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_status    = status_ff;
   assign rsp_day_count = count_ff;

endmodule

### sv/dd_controller.sv
// Controller: sequences one item through the datapath and owns the result valid flag.
module dd_controller import dd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dd_cmd_type cmd
);

   typedef enum logic [2:0] {
      IDLE,
      QUO_START,
      QUO_END,
      NUM_END,
      FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd         = '0;
      cmd.load_in = req_valid && req_ready;
      state_in    = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) state_in = QUO_START;
         end
         QUO_START: begin
            cmd.quo_en = 1'b1;
            state_in   = QUO_END;
         end
         QUO_END: begin
            cmd.quo_en  = 1'b1;
            cmd.quo_sel = 1'b1;
            cmd.num_en  = 1'b1;
            state_in    = NUM_END;
         end
         NUM_END: begin
            cmd.num_en  = 1'b1;
            cmd.num_sel = 1'b1;
            state_in    = FINISH;
         end
         FINISH: begin
            cmd.out_en = out_free;
            if (out_free) state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.out_en) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

### sv/date_difference_days.sv
// Top level of the Gregorian date difference block.
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_ready  | start and end year, month, day
//   rsp_    | out       | rsp_valid/rsp_ready  | status, day_count
//
// After acceptance the states QUO_START, QUO_END, NUM_END and FINISH take the start and
// end years through the shared year quotient unit, the start and end dates through the
// day number unit and the final subtract into the output register. A new beat is taken
// while the previous result waits in the output register; a held result stalls only the
// final step. Reset is synchronous and clears the controller and the result valid flag.
module date_difference_days import dd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [YEAR_W-1:0]   req_start_year,
   input  logic [MONTH_W-1:0]  req_start_month,
   input  logic [DAY_W-1:0]    req_start_day,
   input  logic [YEAR_W-1:0]   req_end_year,
   input  logic [MONTH_W-1:0]  req_end_month,
   input  logic [DAY_W-1:0]    req_end_day,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_day_count
);

   dd_cmd_type cmd;

   dd_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   dd_datapath u_dp (
      .clock           (clock),
      .cmd             (cmd),
      .req_start_year  (req_start_year),
      .req_start_month (req_start_month),
      .req_start_day   (req_start_day),
      .req_end_year    (req_end_year),
      .req_end_month   (req_end_month),
      .req_end_day     (req_end_day),
      .rsp_status      (rsp_status),
      .rsp_day_count   (rsp_day_count)
   );

endmodule

### sv/dd_checker.sv
// Port checker for the date difference block, bound to the top level.
module dd_checker import dd_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [COUNT_W-1:0]  rsp_day_count
);

   // A result beat that is not taken holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_day_count))
      else $error("held result beat changed");

   // Every error result carries a zero day count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_day_count == '0)
      else $error("non-zero day count on an error result");

   // Only defined status codes appear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_ORDER)
      else $error("undefined status code");

   // One item is in work at a time, so an accepted beat closes the input for the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input open directly after an accepted beat");

endmodule

bind date_difference_days dd_checker u_dd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_status    (rsp_status),
   .rsp_day_count (rsp_day_count)
);
